>>> src/palindrome_min_cut_assert.svh
// ----------------------------------------------------------------------------
// palindrome_min_cut_assert.svh
// Assertion macros for the palindrome min-cut block checker.
// ----------------------------------------------------------------------------
`ifndef PALINDROME_MIN_CUT_ASSERT_SVH
`define PALINDROME_MIN_CUT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palindrome_min_cut: implication check failed");

// next-cycle implication, sampled on clk, off during reset
`define PMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palindrome_min_cut: next-cycle check failed");

`endif

>>> src/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// Constants and controller/datapath interface types for palindrome_min_cut.
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int MAX_LEN = 64;
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int SYM_W   = 8;
	localparam int CUT_W   = 6;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [CUT_W-1:0] cut_t;

	typedef struct packed {
		logic start;
		logic drop;
		logic issue;
		logic wrap;
		logic fin_rd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic j_end;
		logic last;
		logic out_free;
	} sts_t;

endpackage

>>> src/pmc_in_if.sv
// ----------------------------------------------------------------------------
// pmc_in_if
// Input channel: one string byte per item, with an end-of-string flag.
// ----------------------------------------------------------------------------
interface pmc_in_if;
	import pmc_pkg::*;

	logic valid;
	logic ready;
	sym_t symbol;
	logic last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> src/pmc_out_if.sv
// ----------------------------------------------------------------------------
// pmc_out_if
// Output channel: one result item per string.
// ----------------------------------------------------------------------------
interface pmc_out_if;
	import pmc_pkg::*;

	logic valid;
	logic ready;
	cut_t min_cuts;
	logic too_long;

	modport source (output valid, output min_cuts, output too_long, input ready);
	modport sink   (input valid, input min_cuts, input too_long, output ready);
endinterface

>>> src/palindrome_min_cut.sv
// A stored byte walks the byte/cut memories over every position up to its own,
// then drains and commits the column. A final byte adds a cut read and output load
// before the result item. Bytes past the limit are dropped and skip the walk.
// The walk over stored positions through the byte/cut memories sets the rate.
// Asynchronous active-low reset empties the string and the output register;
// the memories keep their contents and need no clearing.
// ----------------------------------------------------------------------------
// palindrome_min_cut
// Least palindrome partition cuts of a byte string, column by column.
// ----------------------------------------------------------------------------
module palindrome_min_cut (
	input  logic      clk,
	input  logic      arst_n,
	pmc_in_if.sink    in_ch,
	pmc_out_if.source out_ch
);
	import pmc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pmc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_symbol    (in_ch.symbol),
		.in_last      (in_ch.last),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_min_cuts (out_ch.min_cuts),
		.out_too_long (out_ch.too_long)
	);

endmodule

>>> src/pmc_ctrl.sv
// ----------------------------------------------------------------------------
// pmc_ctrl
// Sequencer: accepts a byte, walks the stored positions, commits the column
// and issues the result on the final byte; bytes past the limit are dropped.
// ----------------------------------------------------------------------------
module pmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  pmc_pkg::sts_t sts,
	output pmc_pkg::cmd_t cmd
);
	import pmc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RUN   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_WRAP  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (!sts.full) begin
						cmd.start = 1'b1;
						state_d   = S_RUN;
					end else begin
						cmd.drop = 1'b1;
						if (in_last)
							state_d = S_FIN;
					end
				end
			end
			S_RUN: begin
				cmd.issue = 1'b1;
				if (sts.j_end)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_WRAP;
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = sts.last ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				cmd.fin_rd = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> src/pmc_dp.sv
// ----------------------------------------------------------------------------
// pmc_dp
// Datapath: byte and cut memories, palindrome column, running minimum and
// the output register.
// ----------------------------------------------------------------------------
module pmc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  pmc_pkg::cmd_t cmd,
	output pmc_pkg::sts_t sts,
	input  pmc_pkg::sym_t in_symbol,
	input  logic          in_last,
	output logic          out_valid,
	input  logic          out_ready,
	output pmc_pkg::cut_t out_min_cuts,
	output logic          out_too_long
);
	import pmc_pkg::*;

	sym_t             char_mem [MAX_LEN];
	cut_t             cut_mem  [MAX_LEN];

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [MAX_LEN-1:0] pal_q;
	logic [MAX_LEN-1:0] next_q;
	cut_t             best_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	sym_t             sym_q;
	logic             last_q;

	logic             vld_s1;
	logic [IDX_W-1:0] j_s1;
	sym_t             char_rd_q;
	cut_t             cut_rd_q;

	logic             out_valid_q;
	cut_t             out_cuts_q;
	logic             out_long_q;

	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] cut_addr;
	logic [IDX_W-1:0] diff;
	logic [IDX_W-1:0] jp1;
	logic             inner;
	logic             hit;
	logic [CUT_W:0]   cand;
	logic             better;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign cut_addr = cmd.issue ? (j_q - IDX_W'(1)) : cnt_m1[IDX_W-1:0];

	assign diff   = i_q - j_s1;
	assign jp1    = j_s1 + IDX_W'(1);
	assign inner  = (diff == '0) || (diff == IDX_W'(1)) ||
	                ((j_s1 != IDX_W'(MAX_LEN - 1)) && pal_q[jp1]);
	assign hit    = (char_rd_q == sym_q) && inner;
	assign cand   = (j_s1 == '0) ? '0 : ({1'b0, cut_rd_q} + (CUT_W+1)'(1));
	assign better = cand < {1'b0, best_q};

	assign sts.full     = (count_q == CNT_W'(MAX_LEN));
	assign sts.j_end    = (j_q == i_q);
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_min_cuts = out_cuts_q;
	assign out_too_long = out_long_q;

	always_ff @(posedge clk) begin
		if (cmd.start)
			char_mem[count_q[IDX_W-1:0]] <= in_symbol;
		if (cmd.issue)
			char_rd_q <= char_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wrap)
			cut_mem[i_q] <= best_q;
		if (cmd.issue || cmd.fin_rd)
			cut_rd_q <= cut_mem[cut_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			pal_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.drop)
				ovf_q <= 1'b1;
			if (cmd.wrap) begin
				pal_q   <= next_q;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				ovf_q       <= 1'b0;
				pal_q       <= '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sym_q  <= in_symbol;
			last_q <= in_last;
			i_q    <= count_q[IDX_W-1:0];
			j_q    <= '0;
			next_q <= '0;
			best_q <= CUT_W'(count_q[IDX_W-1:0]);
		end
		if (cmd.issue) begin
			j_s1 <= j_q;
			j_q  <= j_q + IDX_W'(1);
		end
		if (vld_s1 && hit) begin
			next_q[j_s1] <= 1'b1;
			if (better)
				best_q <= cand[CUT_W-1:0];
		end
		if (cmd.load_out) begin
			out_cuts_q <= cut_rd_q;
			out_long_q <= ovf_q;
		end
	end

endmodule

>>> src/pmc_checker.sv
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks for palindrome_min_cut, bound to the top level.
// ----------------------------------------------------------------------------
`include "palindrome_min_cut_assert.svh"

module pmc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          in_last,
	input logic          out_valid,
	input logic          out_ready,
	input pmc_pkg::cut_t out_min_cuts,
	input logic          out_too_long
);
	import pmc_pkg::*;

	// stalled result holds
	`PMC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_min_cuts) && $stable(out_too_long))

	// a final byte always keeps the block busy the next cycle
	`PMC_ASSERT_NXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready)

	// a new result is only loaded while input is held off
	`PMC_ASSERT_IMP(a_load_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind palindrome_min_cut pmc_checker u_pmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_last      (in_ch.last),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_min_cuts (out_ch.min_cuts),
	.out_too_long (out_ch.too_long)
);

>>> bench/tb_palindrome_min_cut.sv
// ----------------------------------------------------------------------------
// tb_palindrome_min_cut
// Self-checking bench for the palindrome min-cut block. Strings are sent one
// byte per item; a column-by-column model of the cut search predicts each
// result, which is compared field by field with what the block returns.
// Covers short directed strings, the longest strings, overflow, output
// back-pressure and random strings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_palindrome_min_cut;
	import pmc_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 160;

	typedef struct packed {
		cut_t min_cuts;
		logic too_long;
	} cut_result_t;

	logic clk;
	logic arst_n;

	pmc_in_if  in_ch();
	pmc_out_if out_ch();

	palindrome_min_cut uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// model of the string under way
	sym_t             str_bytes [MAX_LEN];
	cut_t             prefix_cuts [MAX_LEN];
	logic [MAX_LEN-1:0] pal_col;
	int               str_len;
	logic             str_overflow;

	cut_result_t cut_results_q[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	bit src_idle_en    = 1'b0;
	bit sink_idle_en   = 1'b0;
	bit hold_req       = 1'b0;

	// symbol source for random strings
	sym_t draw_set [4];
	int   draw_n;
	bit   draw_any;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_palindrome_min_cut NOT OK");
			$finish;
		end
	end

	function automatic void clear_string();
		pal_col      = '0;
		str_len      = 0;
		str_overflow = 1'b0;
	endfunction

	// one accepted byte: extend the palindrome column and the prefix cuts
	function automatic void track_min_cut(sym_t s, logic fin);
		logic [MAX_LEN-1:0] col_next;
		int                 pos;
		int                 best;
		int                 cand;
		cut_result_t        res;

		if (str_len < MAX_LEN) begin
			pos            = str_len;
			str_bytes[pos] = s;
			col_next       = '0;
			best           = pos;
			for (int j = 0; j <= pos; j++) begin
				if (str_bytes[j] == s && (pos - j < 2 || (j < MAX_LEN - 1 && pal_col[j+1]))) begin
					col_next[j] = 1'b1;
					cand = (j == 0) ? 0 : int'(prefix_cuts[j-1]) + 1;
					if (cand < best)
						best = cand;
				end
			end
			pal_col          = col_next;
			prefix_cuts[pos] = cut_t'(best);
			str_len          = pos + 1;
		end else begin
			str_overflow = 1'b1;
		end
		if (fin) begin
			res.min_cuts = prefix_cuts[str_len-1];
			res.too_long = str_overflow;
			cut_results_q = {cut_results_q, res};
			clear_string();
		end
	endfunction

	function automatic sym_t draw_symbol();
		if (draw_any)
			return sym_t'($urandom_range(0, 255));
		return draw_set[$urandom_range(0, draw_n - 1)];
	endfunction

	// random string: plain, a single palindrome, or a chain of short palindromes
	function automatic void make_string(output sym_t str[$], input int len);
		int style;
		int half;
		int seg;
		int base;

		str = {};
		foreach (draw_set[a])
			draw_set[a] = sym_t'($urandom_range(0, 255));
		draw_n   = $urandom_range(1, 4);
		draw_any = ($urandom_range(0, 3) == 0);
		style    = $urandom_range(0, 3);
		case (style)
			2: begin
				half = (len + 1) / 2;
				for (int k = 0; k < half; k++)
					str = {str, draw_symbol()};
				for (int k = len / 2 - 1; k >= 0; k--)
					str = {str, str[k]};
			end
			3: begin
				while (str.size() < len) begin
					seg  = $urandom_range(1, 5);
					if (seg > len - str.size())
						seg = len - str.size();
					base = str.size();
					for (int k = 0; k < seg; k++) begin
						if (k < (seg + 1) / 2)
							str = {str, draw_symbol()};
						else
							str = {str, str[base + seg - 1 - k]};
					end
				end
			end
			default: begin
				for (int k = 0; k < len; k++)
					str = {str, draw_symbol()};
			end
		endcase
	endfunction

	task automatic send_symbol(input sym_t s, input logic fin);
		in_ch.valid  <= 1'b1;
		in_ch.symbol <= s;
		in_ch.last   <= fin;
		do @(posedge clk); while (!in_ch.ready);
		track_min_cut(s, fin);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_string(input sym_t str[$]);
		foreach (str[k])
			send_symbol(str[k], k == str.size() - 1);
	endtask

	task automatic test_directed();
		sym_t str[$];

		str = {8'h00};                            send_string(str);
		str = {8'hFF};                            send_string(str);
		str = {8'h61, 8'h62};                     send_string(str);
		str = {8'h61, 8'h62, 8'h61};              send_string(str);
		str = {8'h61, 8'h61, 8'h62};              send_string(str);
		str = {8'h55, 8'hAA, 8'hAA, 8'h55};       send_string(str);
		str = {8'h01, 8'h02, 8'h01, 8'h02, 8'h02}; send_string(str);
	endtask

	// full-length strings: all distinct gives the largest cut count
	task automatic test_full_length();
		sym_t str[$];
		int   base;

		base = $urandom_range(0, 255);
		str  = {};
		for (int k = 0; k < MAX_LEN; k++)
			str = {str, sym_t'(base + k)};
		send_string(str);
		str = {};
		for (int k = 0; k < MAX_LEN; k++)
			str = {str, sym_t'(base)};
		send_string(str);
		make_string(str, MAX_LEN);
		send_string(str);
	endtask

	task automatic test_overflow();
		sym_t str[$];

		make_string(str, MAX_LEN + 1);
		send_string(str);
		make_string(str, $urandom_range(MAX_LEN + 2, MAX_LEN + 8));
		send_string(str);
	endtask

	// output held off while strings keep coming, so the input must stall
	task automatic test_backpressure();
		sym_t str[$];

		src_idle_en = 1'b0;
		hold_req    = 1'b1;
		for (int n = 0; n < 6; n++) begin
			make_string(str, $urandom_range(2, 4));
			send_string(str);
		end
	endtask

	task automatic test_random(input int n_items);
		sym_t str[$];
		int   sent;
		int   pick;
		int   len;

		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = $urandom_range(33, MAX_LEN);
			else if (pick == 1)
				len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
			else
				len = $urandom_range(1, 12);
			make_string(str, len);
			send_string(str);
			sent += (len > MAX_LEN) ? MAX_LEN : len;
		end
	endtask

	// result ready, with random stalls and one long hold
	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cut_result_t want;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cut_results_q.size() == 0) begin
				$error("unexpected result item: min_cuts %0d too_long %0b",
					out_ch.min_cuts, out_ch.too_long);
				mismatch_count++;
			end else begin
				want = cut_results_q.pop_front();
				if (out_ch.min_cuts !== want.min_cuts) begin
					$error("min_cuts: expected %0d, actual %0d", want.min_cuts, out_ch.min_cuts);
					mismatch_count++;
				end
				if (out_ch.too_long !== want.too_long) begin
					$error("too_long: expected %0b, actual %0b", want.too_long, out_ch.too_long);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.symbol <= '0;
		in_ch.last   <= 1'b0;
		clear_string();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		test_directed();
		test_full_length();
		test_overflow();
		test_backpressure();
		src_idle_en = 1'b1;
		test_random(1130);

		// last stretch runs flat out
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		test_random(250);

		in_ch.valid <= 1'b0;
		while (cut_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && cut_results_q.size() == 0)
			$display("tb_palindrome_min_cut OK");
		else
			$display("tb_palindrome_min_cut NOT OK");
		$finish;
	end

endmodule
